// ----- hw/rtl/cartridge_segment_bank_mapper_macros.svh -----
// Assertion macros used by the top level of the segment bank mapper.
`ifndef CARTRIDGE_SEGMENT_BANK_MAPPER_MACROS_SVH
`define CARTRIDGE_SEGMENT_BANK_MAPPER_MACROS_SVH

`ifndef SYNTHESIS
// Checked property, disabled while reset is high.
`define CSBM_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("csbm assertion failed");
// Checked property, also checked during reset.
`define CSBM_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("csbm assertion failed");
`else
`define CSBM_ASSERT(lbl, clk, rst, prop)
`define CSBM_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ----- hw/rtl/csbm_pkg.sv -----
// Types and constants of the cartridge segment bank mapper.
`default_nettype none

package csbm_pkg;

  // Result kind of one bus access
  typedef enum logic [2:0] {
    TGT_NONE      = 3'd0,
    TGT_VIDEO     = 3'd1,
    TGT_ROM_READ  = 3'd2,
    TGT_RAM_READ  = 3'd3,
    TGT_RAM_WRITE = 3'd4,
    TGT_IGNORED   = 3'd5
  } target_t;

  // Bus operation codes
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Hotspot addresses (low seven bits inside the video window)
  localparam logic [6:0] ADDR_ROM_SWITCH = 7'h3F;
  localparam logic [6:0] ADDR_RAM_SWITCH = 7'h3E;

  // RAM segment half size in bytes
  localparam int unsigned RAM_HALF = 512;
  localparam int unsigned NUM_BANK_CODES = 64;

  // Widths of the item fields
  localparam int unsigned ADDR_W = 13;
  localparam int unsigned DATA_W = 8;
  localparam int unsigned ROM_W  = 16;
  localparam int unsigned BANK_W = 6;
  localparam int unsigned SEG_W  = 2;
  localparam int unsigned NUM_SEGS = 4;

  // Decoded access handed from the decoder to the pipeline
  typedef struct packed {
    target_t           target;
    logic [ROM_W-1:0]  rom_address;
    logic              ram_en;
    logic              ram_we;
  } dec_t;

endpackage

`default_nettype wire

// ----- hw/rtl/csbm_ram.sv -----
// Generic single-port synchronous RAM with registered read data.
`default_nettype none

module csbm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, or read into the output register; rdata holds otherwise
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/csbm_decode.sv -----
// Segment bank registers and address decode of one bus access.
`default_nettype none

module csbm_decode #(
  parameter int unsigned RAM_BYTES = 32768
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           accept,
  input  wire logic                           operation,
  input  wire logic [csbm_pkg::ADDR_W-1:0]    bus_address,
  input  wire logic [csbm_pkg::DATA_W-1:0]    write_data,
  output csbm_pkg::dec_t                      dec,
  output logic      [$clog2(RAM_BYTES)-1:0]   ram_addr
);

  localparam int unsigned IDX_W = $clog2(RAM_BYTES);

  // Bit 6: RAM bank, bits 5:0: bank number
  logic [csbm_pkg::BANK_W:0] bank_q [csbm_pkg::NUM_SEGS];

  logic [csbm_pkg::SEG_W-1:0]  seg;
  logic [csbm_pkg::BANK_W:0]   entry;
  logic [csbm_pkg::BANK_W-1:0] bank;
  logic                        is_ram;
  logic                        is_write;
  logic                        in_video;
  logic                        in_cart;
  logic                        write_port;
  logic                        sw_rom;
  logic                        sw_ram;
  logic [IDX_W-1:0]            bank_base [csbm_pkg::NUM_BANK_CODES];
  logic [IDX_W:0]              idx_sum;

  // Base of each RAM bank, already reduced modulo the RAM size
  for (genvar g = 0; g < csbm_pkg::NUM_BANK_CODES; g++) begin : g_base
    assign bank_base[g] = IDX_W'((g * csbm_pkg::RAM_HALF) % RAM_BYTES);
  end

  assign is_write   = (operation == csbm_pkg::OP_WRITE);
  assign seg        = bus_address[11:10];
  assign entry      = bank_q[seg];
  assign bank       = entry[csbm_pkg::BANK_W-1:0];
  assign is_ram     = entry[csbm_pkg::BANK_W];
  assign in_video   = (bus_address[12:7] == 6'd0);
  assign in_cart    = bus_address[12];
  assign write_port = bus_address[9];
  assign sw_rom     = in_video && is_write && (bus_address[6:0] == csbm_pkg::ADDR_ROM_SWITCH);
  assign sw_ram     = in_video && is_write && (bus_address[6:0] == csbm_pkg::ADDR_RAM_SWITCH);

  // RAM index: base plus offset, one wrap at most
  assign idx_sum = {1'b0, bank_base[bank]} + (IDX_W + 1)'(bus_address[8:0]);
  always_comb begin
    if (idx_sum >= (IDX_W + 1)'(RAM_BYTES)) begin
      ram_addr = IDX_W'(idx_sum - (IDX_W + 1)'(RAM_BYTES));
    end else begin
      ram_addr = idx_sum[IDX_W-1:0];
    end
  end

  // Classify the access
  always_comb begin
    dec.target      = csbm_pkg::TGT_NONE;
    dec.rom_address = '0;
    dec.ram_en      = 1'b0;
    dec.ram_we      = 1'b0;
    if (in_video) begin
      dec.target = csbm_pkg::TGT_VIDEO;
    end else if (in_cart) begin
      if (!is_ram) begin
        if (is_write) begin
          dec.target = csbm_pkg::TGT_IGNORED;
        end else begin
          dec.target      = csbm_pkg::TGT_ROM_READ;
          dec.rom_address = {bank, bus_address[9:0]};
        end
      end else if (is_write && write_port) begin
        dec.target = csbm_pkg::TGT_RAM_WRITE;
        dec.ram_en = 1'b1;
        dec.ram_we = 1'b1;
      end else if (!is_write && !write_port) begin
        dec.target = csbm_pkg::TGT_RAM_READ;
        dec.ram_en = 1'b1;
      end else begin
        dec.target = csbm_pkg::TGT_IGNORED;
      end
    end
  end

  // Bank switch writes take effect for the next access
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < csbm_pkg::NUM_SEGS; i++) begin
        bank_q[i] <= '0;
      end
    end else if (accept && (sw_rom || sw_ram)) begin
      bank_q[write_data[7:6]] <= {sw_ram, write_data[csbm_pkg::BANK_W-1:0]};
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/cartridge_segment_bank_mapper.sv -----
// Top level of the cartridge segment bank mapper: decode, RAM and output pipeline.
//
//  channel | dir | handshake               | content
//  s_axis  | in  | s_axis_tvalid/tready    | one bus access
//  m_axis  | out | m_axis_tvalid/tready    | one result item per access
//
// One item per cycle while the output is not stalled.
// Stage 0 decodes against the segment bank flops and issues the RAM access;
// stage 1 waits for the registered RAM read; the output register holds the item.
// Bank switches and RAM writes are seen by the very next item, with no bubble.
// Reset clears the bank registers and the pipeline valids and holds tready low;
// RAM is not cleared.
// A stalled output stops stage 1 and then the input; RAM read data is held meanwhile.
`default_nettype none

`include "cartridge_segment_bank_mapper_macros.svh"

module cartridge_segment_bank_mapper #(
  parameter int unsigned RAM_BYTES = 32768
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [0] operation, [13:1] bus_address, [21:14] write_data, [23:22] zero
  input  wire logic [23:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [2:0] target, [18:3] rom_address, [26:19] read_data, [31:27] zero
  output logic      [31:0] m_axis_tdata
);

  localparam int unsigned IDX_W = $clog2(RAM_BYTES);

  logic                           accept;
  csbm_pkg::dec_t                 dec;
  logic [IDX_W-1:0]               ram_addr;
  logic [csbm_pkg::DATA_W-1:0]    ram_rdata;

  logic                           s1_valid;
  csbm_pkg::target_t              s1_target;
  logic [csbm_pkg::ROM_W-1:0]     s1_rom;
  logic                           s1_adv;
  logic                           out_free;

  logic                           out_valid;
  csbm_pkg::target_t              out_target;
  logic [csbm_pkg::ROM_W-1:0]     out_rom;
  logic [csbm_pkg::DATA_W-1:0]    out_rdata;

  // Handshake; no item is taken while reset is high
  assign out_free      = !out_valid || m_axis_tready;
  assign s1_adv        = s1_valid && out_free;
  assign s_axis_tready = !rst && (!s1_valid || out_free);
  assign accept        = s_axis_tvalid && s_axis_tready;

  csbm_decode #(
    .RAM_BYTES (RAM_BYTES)
  ) u_decode (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .operation   (s_axis_tdata[0]),
    .bus_address (s_axis_tdata[13:1]),
    .write_data  (s_axis_tdata[21:14]),
    .dec         (dec),
    .ram_addr    (ram_addr)
  );

  csbm_ram #(
    .WIDTH (csbm_pkg::DATA_W),
    .DEPTH (RAM_BYTES)
  ) u_ram (
    .clk   (clk),
    .en    (accept && dec.ram_en),
    .we    (dec.ram_we),
    .addr  (ram_addr),
    .wdata (s_axis_tdata[21:14]),
    .rdata (ram_rdata)
  );

  // Stage 1 control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_target <= dec.target;
      s1_rom    <= dec.rom_address;
    end
  end

  // Output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  // Output payload; RAM data only for a RAM read
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_target <= s1_target;
      out_rom    <= s1_rom;
      out_rdata  <= (s1_target == csbm_pkg::TGT_RAM_READ) ? ram_rdata : '0;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'd0, out_rdata, out_rom, out_target};

  `CSBM_ASSERT(a_out_held_in_stall, clk, rst,
               (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
  `CSBM_ASSERT(a_rdata_held_in_stall, clk, rst,
               (s1_valid && !s1_adv) |=> $stable(ram_rdata))
  `CSBM_ASSERT(a_rdata_only_ram_read, clk, rst,
               (out_valid && out_target != csbm_pkg::TGT_RAM_READ) |-> (out_rdata == '0))
  `CSBM_ASSERT(a_rom_only_rom_read, clk, rst,
               (out_valid && out_target != csbm_pkg::TGT_ROM_READ) |-> (out_rom == '0))
  `CSBM_ASSERT_ALWAYS(a_no_valid_in_reset, clk,
                      rst |=> (!s1_valid && !out_valid))

endmodule

`default_nettype wire
